>>> hdl/ryd_pkg.sv
`timescale 1ns / 1ps

package ryd_pkg;

  // field widths
  localparam int SIZE_W       = 11;
  localparam int CFG_INDEX_W  = 3;
  localparam int OFFSET_W     = 21;
  localparam int DIV_COUNT_W  = $clog2(SIZE_W);
  localparam int CMP_W        = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_WIDTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_HEIGHT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANAR_MODE = 3'd4;

  // register values after reset
  localparam int unsigned SRC_WIDTH_RESET   = 800;
  localparam int unsigned SRC_HEIGHT_RESET  = 800;
  localparam int unsigned DST_WIDTH_RESET   = 720;
  localparam int unsigned DST_HEIGHT_RESET  = 720;
  localparam logic        PLANAR_MODE_RESET = 1'b1;

  // plane codes
  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  // colour conversion coefficients
  localparam int unsigned COEF_YR     = 19595;
  localparam int unsigned COEF_YG     = 38470;
  localparam int unsigned COEF_YB     = 7471;
  localparam int unsigned COEF_UR     = 100;
  localparam int unsigned COEF_UG     = 208;
  localparam int unsigned COEF_UB     = 308;
  localparam int unsigned COEF_VR     = 308;
  localparam int unsigned COEF_VG     = 261;
  localparam int unsigned COEF_VB     = 47;
  localparam int unsigned CHROMA_BIAS = 32768;
  localparam logic [7:0]  BYTE_MAX    = 8'd255;

  typedef enum logic {
    SETUP_DIVIDE,
    SETUP_DONE
  } setup_state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] dest_offset;
    logic [7:0]          value;
    logic [1:0]          plane;
    logic                last;
    logic                frame_done;
  } result_t;

  // source size limited to 2..max_size
  function automatic logic [SIZE_W-1:0] eff_src_size(logic [SIZE_W-1:0] v,
                                                     int unsigned max_size);
    logic [SIZE_W:0] s;
    s = {1'b0, v};
    if (int'(s) > max_size) s = (SIZE_W+1)'(max_size);
    if (s < (SIZE_W+1)'(2)) s = (SIZE_W+1)'(2);
    return s[SIZE_W-1:0];
  endfunction

  // output size: limited, made even, not above the even source size, at least 2
  function automatic logic [SIZE_W-1:0] eff_dst_size(logic [SIZE_W-1:0] d,
                                                     logic [SIZE_W-1:0] s_eff,
                                                     int unsigned max_size);
    logic [SIZE_W:0] w;
    logic [SIZE_W:0] lim;
    w = {1'b0, d};
    if (int'(w) > max_size) w = (SIZE_W+1)'(max_size);
    w[0] = 1'b0;
    lim = {1'b0, s_eff[SIZE_W-1:1], 1'b0};
    if (w > lim) w = lim;
    if (w < (SIZE_W+1)'(2)) w = (SIZE_W+1)'(2);
    return w[SIZE_W-1:0];
  endfunction

endpackage

>>> hdl/ryd_pixel_if.sv
`timescale 1ns / 1ps

interface ryd_pixel_if;
  logic            valid;
  logic            ready;
  ryd_pkg::pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/ryd_result_if.sv
`timescale 1ns / 1ps

interface ryd_result_if;
  logic             valid;
  logic             ready;
  ryd_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/rgb_to_yuv420_downscaler.sv
`timescale 1ns / 1ps
// A picked pixel's luma byte passes the stage b and stage c registers, then the output register.
// Throughput: one pixel per cycle while results are taken and no setup or fixup runs; a pixel
// that closes a 2x2 block holds the input until its luma, U and V bytes leave the single output register.
// Reset: counters clear, then a restoring divider works out the sample steps with input ready low;
// the same pass runs after every register write. The line buffer is not cleared.
module rgb_to_yuv420_downscaler #(
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_SRC_HEIGHT = 1024,
  parameter int MAX_DST_WIDTH  = 1024,
  parameter int MAX_DST_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  ryd_pixel_if.sink                          pixels,
  ryd_result_if.source                       results,
  input  logic                               cfg_we,
  input  logic [ryd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ryd_pkg::SIZE_W-1:0]         cfg_data
);

  localparam int SW_ = ryd_pkg::SIZE_W;
  localparam int OW  = ryd_pkg::OFFSET_W;
  localparam int CW  = ryd_pkg::CMP_W;
  localparam int XW  = $clog2(MAX_SRC_WIDTH);
  localparam int YW  = $clog2(MAX_SRC_HEIGHT);
  // next sample counters get room for overshoot past the row end
  localparam int NXW = XW + 2;
  localparam int NYW = YW + 2;
  localparam int OXW = $clog2(MAX_DST_WIDTH + 1);
  localparam int OYW = $clog2(MAX_DST_HEIGHT + 1);
  localparam int LINE_SLOTS = (MAX_DST_WIDTH + 1) / 2;
  localparam int AW = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;

  localparam int unsigned RESET_SW = ryd_pkg::eff_src_size(
      SW_'(ryd_pkg::SRC_WIDTH_RESET), MAX_SRC_WIDTH);
  localparam int unsigned RESET_SH = ryd_pkg::eff_src_size(
      SW_'(ryd_pkg::SRC_HEIGHT_RESET), MAX_SRC_HEIGHT);
  localparam int unsigned RESET_EW = ryd_pkg::eff_dst_size(
      SW_'(ryd_pkg::DST_WIDTH_RESET), SW_'(RESET_SW), MAX_DST_WIDTH);
  localparam int unsigned RESET_EH = ryd_pkg::eff_dst_size(
      SW_'(ryd_pkg::DST_HEIGHT_RESET), SW_'(RESET_SH), MAX_DST_HEIGHT);
  localparam logic [OW-1:0] RESET_CHROMA = OW'(RESET_EW * RESET_EH);

  // configuration registers
  logic [SW_-1:0] src_width, src_height, dst_width, dst_height;
  logic           planar_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width   <= SW_'(ryd_pkg::SRC_WIDTH_RESET);
      src_height  <= SW_'(ryd_pkg::SRC_HEIGHT_RESET);
      dst_width   <= SW_'(ryd_pkg::DST_WIDTH_RESET);
      dst_height  <= SW_'(ryd_pkg::DST_HEIGHT_RESET);
      planar_mode <= ryd_pkg::PLANAR_MODE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ryd_pkg::REG_SRC_WIDTH:   src_width   <= cfg_data;
        ryd_pkg::REG_SRC_HEIGHT:  src_height  <= cfg_data;
        ryd_pkg::REG_DST_WIDTH:   dst_width   <= cfg_data;
        ryd_pkg::REG_DST_HEIGHT:  dst_height  <= cfg_data;
        ryd_pkg::REG_PLANAR_MODE: planar_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [SW_-1:0] sw, sh, ew, eh;
  assign sw = ryd_pkg::eff_src_size(src_width, MAX_SRC_WIDTH);
  assign sh = ryd_pkg::eff_src_size(src_height, MAX_SRC_HEIGHT);
  assign ew = ryd_pkg::eff_dst_size(dst_width, sw, MAX_DST_WIDTH);
  assign eh = ryd_pkg::eff_dst_size(dst_height, sh, MAX_DST_HEIGHT);

  // luma plane size, registered
  logic [2*SW_-1:0] luma_size;
  logic [OW-1:0]    quarter_size;

  always_ff @(posedge clk) begin
    luma_size <= ew * eh;
  end

  assign quarter_size = OW'(luma_size[2*SW_-1:2]);

  // setup sequencer: one quotient bit per cycle for sw/ew and sh/eh
  ryd_pkg::setup_state_t setup_state, setup_state_next;
  logic [ryd_pkg::DIV_COUNT_W-1:0] div_count;
  logic [ryd_pkg::DIV_COUNT_W-1:0] div_bit;
  logic [SW_-1:0] col_step, col_frac, row_step, row_frac;
  logic [SW_-1:0] col_step_next, col_frac_next, row_step_next, row_frac_next;
  logic [SW_:0]   col_part, row_part;

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_state <= ryd_pkg::SETUP_DIVIDE;
    end else begin
      setup_state <= setup_state_next;
    end
  end

  always_comb begin
    setup_state_next = setup_state;
    case (setup_state)
      ryd_pkg::SETUP_DIVIDE: begin
        if (div_count == ryd_pkg::DIV_COUNT_W'(SW_ - 1)) begin
          setup_state_next = ryd_pkg::SETUP_DONE;
        end
      end
      ryd_pkg::SETUP_DONE: ;
      default: setup_state_next = ryd_pkg::SETUP_DIVIDE;
    endcase
    if (cfg_we) setup_state_next = ryd_pkg::SETUP_DIVIDE;
  end

  // restoring division step
  always_comb begin
    div_bit  = ryd_pkg::DIV_COUNT_W'(SW_ - 1) - div_count;
    col_part = {col_frac, sw[div_bit]};
    row_part = {row_frac, sh[div_bit]};
    if (col_part >= {1'b0, ew}) begin
      col_frac_next = SW_'(col_part - {1'b0, ew});
      col_step_next = {col_step[SW_-2:0], 1'b1};
    end else begin
      col_frac_next = col_part[SW_-1:0];
      col_step_next = {col_step[SW_-2:0], 1'b0};
    end
    if (row_part >= {1'b0, eh}) begin
      row_frac_next = SW_'(row_part - {1'b0, eh});
      row_step_next = {row_step[SW_-2:0], 1'b1};
    end else begin
      row_frac_next = row_part[SW_-1:0];
      row_step_next = {row_step[SW_-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      div_count <= '0;
      col_step  <= '0;
      col_frac  <= '0;
      row_step  <= '0;
      row_frac  <= '0;
    end else if (setup_state == ryd_pkg::SETUP_DIVIDE) begin
      div_count <= div_count + 1'b1;
      col_step  <= col_step_next;
      col_frac  <= col_frac_next;
      row_step  <= row_step_next;
      row_frac  <= row_frac_next;
    end
  end

  // position state
  logic [XW-1:0]  source_column, source_column_next, cur_source_column;
  logic [YW-1:0]  source_row, source_row_next, cur_source_row;
  logic [OXW-1:0] output_column, output_column_next, cur_output_column;
  logic [OYW-1:0] output_row, output_row_next, cur_output_row;
  logic [NXW-1:0] next_sample_column, next_sample_column_next, cur_next_sample_column;
  logic [NYW-1:0] next_sample_row, next_sample_row_next, cur_next_sample_row;
  logic [SW_-1:0] column_remainder, column_remainder_next, cur_column_remainder;
  logic [SW_-1:0] row_remainder, row_remainder_next, cur_row_remainder;
  logic [OW-1:0]  luma_position, luma_position_next, cur_luma_position;
  logic [OW-1:0]  chroma_position, chroma_position_next, cur_chroma_position;
  logic [23:0]    held_sample_rgb;
  logic           column_fixup, column_fixup_next, row_fixup, row_fixup_next;

  logic           accept, adv;
  logic           row_picked, picked, odd_col, odd_row, closes, final_px, row_end;
  logic [SW_:0]   col_sum, col_sum_red, row_sum, row_sum_red;
  logic           col_carry, row_carry;
  logic [8:0]     sum_r, sum_g, sum_b;
  logic [AW-1:0]  slot;
  logic [OW-1:0]  v_offset;
  logic           rd_en, wr_en;

  assign accept = pixels.valid && pixels.ready;
  assign pixels.ready = (setup_state == ryd_pkg::SETUP_DONE) && !column_fixup &&
                        !row_fixup && adv;

  // frame start restarts every position counter for this pixel
  always_comb begin
    if (pixels.data.frame_start) begin
      cur_source_column      = '0;
      cur_source_row         = '0;
      cur_output_column      = '0;
      cur_output_row         = '0;
      cur_next_sample_column = '0;
      cur_next_sample_row    = '0;
      cur_column_remainder   = '0;
      cur_row_remainder      = '0;
      cur_luma_position      = '0;
      cur_chroma_position    = OW'(luma_size);
    end else begin
      cur_source_column      = source_column;
      cur_source_row         = source_row;
      cur_output_column      = output_column;
      cur_output_row         = output_row;
      cur_next_sample_column = next_sample_column;
      cur_next_sample_row    = next_sample_row;
      cur_column_remainder   = column_remainder;
      cur_row_remainder      = row_remainder;
      cur_luma_position      = luma_position;
      cur_chroma_position    = chroma_position;
    end
  end

  // sample selection and block position
  always_comb begin
    row_picked = (CW'(cur_source_row) == CW'(cur_next_sample_row)) &&
                 (CW'(cur_output_row) < CW'(eh));
    picked     = row_picked &&
                 (CW'(cur_source_column) == CW'(cur_next_sample_column)) &&
                 (CW'(cur_output_column) < CW'(ew));
    odd_col    = cur_output_column[0];
    odd_row    = cur_output_row[0];
    closes     = odd_col && odd_row;
    final_px   = (CW'(cur_output_row) == CW'(eh) - CW'(1)) &&
                 (CW'(cur_output_column) == CW'(ew) - CW'(1));
    row_end    = (CW'(cur_source_column) + CW'(1)) >= CW'(sw);
    slot       = cur_output_column[AW:1];
    sum_r      = 9'(pixels.data.red) + 9'(held_sample_rgb[23:16]);
    sum_g      = 9'(pixels.data.green) + 9'(held_sample_rgb[15:8]);
    sum_b      = 9'(pixels.data.blue) + 9'(held_sample_rgb[7:0]);
    v_offset   = planar_mode ? cur_chroma_position + quarter_size
                             : cur_chroma_position + OW'(1);
    rd_en      = accept && picked && closes;
    wr_en      = accept && picked && odd_col && !odd_row;
    // one step of the column and row accumulators, remainder kept below twice the size
    col_sum     = (SW_+1)'(cur_column_remainder) + (SW_+1)'(col_frac);
    col_carry   = col_sum >= (SW_+1)'(ew);
    col_sum_red = col_carry ? col_sum - (SW_+1)'(ew) : col_sum;
    row_sum     = (SW_+1)'(cur_row_remainder) + (SW_+1)'(row_frac);
    row_carry   = row_sum >= (SW_+1)'(eh);
    row_sum_red = row_carry ? row_sum - (SW_+1)'(eh) : row_sum;
  end

  // counter update
  always_comb begin
    source_column_next      = source_column;
    source_row_next         = source_row;
    output_column_next      = output_column;
    output_row_next         = output_row;
    next_sample_column_next = next_sample_column;
    next_sample_row_next    = next_sample_row;
    column_remainder_next   = column_remainder;
    row_remainder_next      = row_remainder;
    luma_position_next      = luma_position;
    chroma_position_next    = chroma_position;
    column_fixup_next       = column_fixup;
    row_fixup_next          = row_fixup;

    // leftover subtractions after a size change, one per cycle
    if (column_fixup) begin
      column_remainder_next   = column_remainder - ew;
      next_sample_column_next = next_sample_column + NXW'(1);
      column_fixup_next       = (column_remainder - ew) >= ew;
    end
    if (row_fixup) begin
      row_remainder_next   = row_remainder - eh;
      next_sample_row_next = next_sample_row + NYW'(1);
      row_fixup_next       = (row_remainder - eh) >= eh;
    end

    if (accept) begin
      output_column_next      = cur_output_column;
      output_row_next         = cur_output_row;
      next_sample_column_next = cur_next_sample_column;
      next_sample_row_next    = cur_next_sample_row;
      column_remainder_next   = cur_column_remainder;
      row_remainder_next      = cur_row_remainder;
      luma_position_next      = cur_luma_position;
      chroma_position_next    = cur_chroma_position;
      source_row_next         = cur_source_row;

      if (picked) begin
        luma_position_next = cur_luma_position + OW'(1);
        if (closes) begin
          chroma_position_next = planar_mode ? cur_chroma_position + OW'(1)
                                             : cur_chroma_position + OW'(2);
        end
        output_column_next      = cur_output_column + OXW'(1);
        next_sample_column_next = cur_next_sample_column + NXW'(col_step) +
                                  NXW'(col_carry);
        column_remainder_next   = col_sum_red[SW_-1:0];
        column_fixup_next       = col_sum_red >= (SW_+1)'(ew);
      end

      if (row_end) begin
        if (row_picked) begin
          output_row_next      = cur_output_row + OYW'(1);
          next_sample_row_next = cur_next_sample_row + NYW'(row_step) + NYW'(row_carry);
          row_remainder_next   = row_sum_red[SW_-1:0];
          row_fixup_next       = row_sum_red >= (SW_+1)'(eh);
        end
        output_column_next      = '0;
        next_sample_column_next = '0;
        column_remainder_next   = '0;
        column_fixup_next       = 1'b0;
        source_column_next      = '0;
        if ((CW'(cur_source_row) + CW'(1)) >= CW'(sh)) begin
          // end of source frame
          source_row_next      = '0;
          output_row_next      = '0;
          next_sample_row_next = '0;
          row_remainder_next   = '0;
          row_fixup_next       = 1'b0;
          luma_position_next   = '0;
          chroma_position_next = OW'(luma_size);
        end else begin
          source_row_next = cur_source_row + YW'(1);
        end
      end else begin
        source_column_next = cur_source_column + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column      <= '0;
      source_row         <= '0;
      output_column      <= '0;
      output_row         <= '0;
      next_sample_column <= '0;
      next_sample_row    <= '0;
      column_remainder   <= '0;
      row_remainder      <= '0;
      luma_position      <= '0;
      chroma_position    <= RESET_CHROMA;
      column_fixup       <= 1'b0;
      row_fixup          <= 1'b0;
      held_sample_rgb    <= '0;
    end else begin
      source_column      <= source_column_next;
      source_row         <= source_row_next;
      output_column      <= output_column_next;
      output_row         <= output_row_next;
      next_sample_column <= next_sample_column_next;
      next_sample_row    <= next_sample_row_next;
      column_remainder   <= column_remainder_next;
      row_remainder      <= row_remainder_next;
      luma_position      <= luma_position_next;
      chroma_position    <= chroma_position_next;
      column_fixup       <= column_fixup_next;
      row_fixup          <= row_fixup_next;
      if (accept && picked && !odd_col) begin
        held_sample_rgb <= {pixels.data.red, pixels.data.green, pixels.data.blue};
      end
    end
  end

  // line buffer of top-row pair sums; a slot is written in an even output row and read in the
  // next output row, so a read never meets a write to the same slot in flight
  logic [26:0] line_mem [0:LINE_SLOTS-1];
  logic [26:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[slot] <= {sum_r, sum_g, sum_b};
    end
    if (rd_en) begin
      rd_data <= line_mem[slot];
    end
  end

  // stage b: luma and block averages
  logic          b_valid, b_closes, b_final;
  logic [23:0]   b_rgb;
  logic [26:0]   b_sum;
  logic [OW-1:0] b_luma_ofs, b_u_ofs, b_v_ofs;
  logic [23:0]   b_ysum;
  logic [9:0]    b_tot_r, b_tot_g, b_tot_b;

  // stage c: chroma and result sequencing
  logic          c_valid, c_closes, c_final;
  logic [7:0]    c_y, c_avg_r, c_avg_g, c_avg_b;
  logic [OW-1:0] c_luma_ofs, c_u_ofs, c_v_ofs;
  logic [1:0]    c_index, c_last_index;
  logic [17:0]   c_tu, c_tv;
  logic [7:0]    c_u, c_v;
  logic          out_load, c_done;
  logic          out_valid;
  ryd_pkg::result_t out_data, out_next;

  always_comb begin
    b_ysum  = 24'(ryd_pkg::COEF_YR * b_rgb[23:16] + ryd_pkg::COEF_YG * b_rgb[15:8] +
                  ryd_pkg::COEF_YB * b_rgb[7:0]);
    b_tot_r = 10'(b_sum[26:18]) + 10'(rd_data[26:18]);
    b_tot_g = 10'(b_sum[17:9]) + 10'(rd_data[17:9]);
    b_tot_b = 10'(b_sum[8:0]) + 10'(rd_data[8:0]);
  end

  assign out_load     = c_valid && (!out_valid || results.ready);
  assign c_last_index = c_closes ? ryd_pkg::PLANE_V : ryd_pkg::PLANE_Y;
  assign c_done       = out_load && (c_index == c_last_index);
  assign adv          = !c_valid || c_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      c_index <= ryd_pkg::PLANE_Y;
    end else begin
      if (adv) begin
        b_valid <= accept && picked;
        c_valid <= b_valid;
        c_index <= ryd_pkg::PLANE_Y;
      end else if (out_load) begin
        c_index <= c_index + 2'd1;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      b_rgb      <= {pixels.data.red, pixels.data.green, pixels.data.blue};
      b_sum      <= {sum_r, sum_g, sum_b};
      b_closes   <= closes;
      b_final    <= final_px;
      b_luma_ofs <= cur_luma_position;
      b_u_ofs    <= cur_chroma_position;
      b_v_ofs    <= v_offset;
      c_y        <= b_ysum[23:16];
      c_avg_r    <= b_tot_r[9:2];
      c_avg_g    <= b_tot_g[9:2];
      c_avg_b    <= b_tot_b[9:2];
      c_closes   <= b_closes;
      c_final    <= b_final;
      c_luma_ofs <= b_luma_ofs;
      c_u_ofs    <= b_u_ofs;
      c_v_ofs    <= b_v_ofs;
    end
  end

  // floor shift by 8 and clamp to a byte
  function automatic logic [7:0] chroma_byte(logic signed [17:0] t);
    logic signed [9:0] q;
    q = 10'(t >>> 8);
    if (q < 10'sd0) return 8'd0;
    if (q > $signed({2'b00, ryd_pkg::BYTE_MAX})) return ryd_pkg::BYTE_MAX;
    return q[7:0];
  endfunction

  always_comb begin
    c_tu = 18'(ryd_pkg::COEF_UB * c_avg_b) + 18'(ryd_pkg::CHROMA_BIAS) -
           18'(ryd_pkg::COEF_UR * c_avg_r) - 18'(ryd_pkg::COEF_UG * c_avg_g);
    c_tv = 18'(ryd_pkg::COEF_VR * c_avg_r) + 18'(ryd_pkg::CHROMA_BIAS) -
           18'(ryd_pkg::COEF_VG * c_avg_g) - 18'(ryd_pkg::COEF_VB * c_avg_b);
    c_u  = chroma_byte($signed(c_tu));
    c_v  = chroma_byte($signed(c_tv));
  end

  // result select: luma, then u and v for a closing pixel
  always_comb begin
    case (c_index)
      ryd_pkg::PLANE_Y: begin
        out_next.dest_offset = c_luma_ofs;
        out_next.value       = c_y;
        out_next.plane       = ryd_pkg::PLANE_Y;
        out_next.last        = !c_closes;
        out_next.frame_done  = c_final && !c_closes;
      end
      ryd_pkg::PLANE_U: begin
        out_next.dest_offset = c_u_ofs;
        out_next.value       = c_u;
        out_next.plane       = ryd_pkg::PLANE_U;
        out_next.last        = 1'b0;
        out_next.frame_done  = 1'b0;
      end
      default: begin
        out_next.dest_offset = c_v_ofs;
        out_next.value       = c_v;
        out_next.plane       = ryd_pkg::PLANE_V;
        out_next.last        = 1'b1;
        out_next.frame_done  = c_final;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

  // checks
  a_setup_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (setup_state != ryd_pkg::SETUP_DONE) |-> !pixels.ready)
    else $error("pixel taken during divider setup");

  a_fixup_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (column_fixup || row_fixup) |-> !pixels.ready)
    else $error("pixel taken while an accumulator is still reducing");

  a_v_follows_u: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && results.data.plane == ryd_pkg::PLANE_U)
    |=> (results.valid && results.data.plane == ryd_pkg::PLANE_V))
    else $error("v byte did not follow its u byte");

  a_stage_b_holds: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !adv) |=> (b_valid && $stable(b_luma_ofs)))
    else $error("stalled pixel lost from stage b");

endmodule
